// File: rtl/sliding_window_peak_count_macros.svh
// Assertion helpers for the sliding window peak counter.
// Each macro names one concurrent assertion clocked on i_clk and disabled in reset.
`ifndef SLIDING_WINDOW_PEAK_COUNT_MACROS_SVH
`define SLIDING_WINDOW_PEAK_COUNT_MACROS_SVH
`ifndef SYNTHESIS
`define SWPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define SWPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWPC_ASSERT_ALWAYS(lbl, prop, msg)
`define SWPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/swpc_pkg.sv
package swpc_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 32;
    localparam int WLEN_W   = 11;
    localparam int PIECES_W = 11;
    localparam int START_W  = 17;
    localparam int PEAKS_W  = 10;

    // Window length after reset, and the ceiling of the running peak count.
    localparam logic [WLEN_W-1:0]  WLEN_RESET = 11'd3;
    localparam logic [PEAKS_W-1:0] PEAKS_SAT  = 10'd1023;

    // Control that every cell of the history chain sees.
    typedef struct packed {
        logic              shift;
        logic              new_bit;
        logic              cfg_we;
        logic [WLEN_W-1:0] cfg_kk;
    } t_chain_ctl;

endpackage

// File: rtl/swpc_cell.sv
module swpc_cell #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swpc_pkg::t_chain_ctl i_ctl,
    input  logic                i_next_bit,
    output logic                o_bit
);

    logic r_sel;
    logic r_bit;

    // This cell is the insertion point when the window length puts it there.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'(IDX == 0);
        end else if (i_ctl.cfg_we) begin
            r_sel <= (32'(IDX) + 32'd3 == 32'(i_ctl.cfg_kk));
        end
    end

    // Peak bits move one cell toward the output on every processed item.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_bit <= r_sel ? i_ctl.new_bit : i_next_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// File: rtl/swpc_chain.sv
module swpc_chain #(
    parameter int N_CELLS = 1022
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swpc_pkg::t_chain_ctl i_ctl,
    output logic                 o_gone
);

    logic [N_CELLS:0] w_bits;

    // The far end of the chain feeds zeros.
    assign w_bits[N_CELLS] = 1'b0;

    // Row of cells; the peak bit that leaves the window falls out of cell zero.
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        swpc_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_next_bit (w_bits[g+1]),
            .o_bit      (w_bits[g])
        );
    end

    assign o_gone = w_bits[0];

endmodule

// File: rtl/sliding_window_peak_count.sv
// Sliding window peak counter. Samples stream in one item per cycle; an item with
// i_last set closes the sequence and produces one result: the best count of peaks
// strictly inside any window of window_length samples, plus one, and the 1-based
// start of the leftmost window that reaches it (1 and 1 when no window scores).
// Each item is finished in the cycle it is accepted, so the block sustains one
// item per cycle. The result sits in an output register; only a last item waits,
// and only while that register still holds an untaken result. Peak bits wait in
// a chain of K_MAX-2 one-bit cells whose insertion point is set by window_length,
// so each bit leaves the chain exactly when it leaves the window. Write
// i_cfg_wdata only between sequences; lengths above K_MAX act as K_MAX. Samples
// past MAX_LEN in one sequence are ignored.
`include "sliding_window_peak_count_macros.svh"

module sliding_window_peak_count #(
    parameter int K_MAX   = 1024,
    parameter int MAX_LEN = 65536
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swpc_pkg::WLEN_W-1:0]         i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [swpc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [swpc_pkg::PIECES_W-1:0]       o_best_pieces,
    output logic [swpc_pkg::START_W-1:0]        o_start_position
);

    localparam int SW = $clog2(MAX_LEN + 1);

    logic [swpc_pkg::WLEN_W-1:0]          r_kk;
    logic [swpc_pkg::WLEN_W-1:0]          n_kk;
    logic [SW-1:0]                        r_seen;
    logic [SW-1:0]                        n_seen;
    logic signed [swpc_pkg::SAMPLE_W-1:0] r_prior;
    logic signed [swpc_pkg::SAMPLE_W-1:0] r_older;
    logic [swpc_pkg::PEAKS_W-1:0]         r_window;
    logic [swpc_pkg::PEAKS_W-1:0]         n_window;
    logic [swpc_pkg::PEAKS_W-1:0]         r_best;
    logic [swpc_pkg::PEAKS_W-1:0]         n_best;
    logic [SW-1:0]                        r_best_start;
    logic [SW-1:0]                        n_best_start;
    logic                                 r_out_valid;
    logic [swpc_pkg::PIECES_W-1:0]        r_best_pieces;
    logic [swpc_pkg::START_W-1:0]         r_start_position;

    logic                                 w_accept;
    logic                                 w_active;
    logic [SW-1:0]                        w_pos;
    logic                                 w_peak;
    logic                                 w_full;
    logic                                 w_gone;
    logic [swpc_pkg::PEAKS_W:0]           w_sum;
    logic [swpc_pkg::PEAKS_W:0]           w_trim;
    logic [swpc_pkg::PEAKS_W-1:0]         w_count;
    swpc_pkg::t_chain_ctl                 w_ctl;

    // Clamp the written window length to the history depth.
    always_comb begin
        n_kk = i_cfg_wdata;
        if (32'(i_cfg_wdata) > 32'(K_MAX)) begin
            n_kk = swpc_pkg::WLEN_W'(K_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kk <= swpc_pkg::WLEN_RESET;
        end else if (i_cfg_we) begin
            r_kk <= n_kk;
        end
    end

    // Input handshake: only a last item needs room in the result register.
    assign o_in_ready = !i_last || !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_active   = w_accept && (32'(r_seen) < 32'(MAX_LEN));
    assign w_pos      = r_seen + SW'(1);

    // The prior sample is a peak when it beats both of its neighbors.
    assign w_peak = (32'(w_pos) >= 32'd3) && (r_prior > r_older) && (r_prior > i_sample);
    assign w_full = (32'(w_pos) >= 32'(r_kk));

    // Running inner peak count of the window that ends at this sample.
    always_comb begin
        w_sum  = {1'b0, r_window} + (swpc_pkg::PEAKS_W + 1)'(w_peak);
        w_trim = w_sum;
        if (w_full) begin
            w_trim = (w_sum >= (swpc_pkg::PEAKS_W + 1)'(w_gone)) ?
                     w_sum - (swpc_pkg::PEAKS_W + 1)'(w_gone) : '0;
        end
        w_count = (w_trim > {1'b0, swpc_pkg::PEAKS_SAT}) ?
                  swpc_pkg::PEAKS_SAT : w_trim[swpc_pkg::PEAKS_W-1:0];
    end

    // Score update; a strictly larger count keeps the leftmost best window.
    always_comb begin
        n_seen       = r_seen;
        n_window     = r_window;
        n_best       = r_best;
        n_best_start = r_best_start;
        if (w_active) begin
            n_seen = w_pos;
            if (r_kk >= swpc_pkg::WLEN_W'(3)) begin
                n_window = w_count;
                if (w_full && (w_count > r_best)) begin
                    n_best       = w_count;
                    n_best_start = SW'(32'(w_pos) - 32'(r_kk) + 32'd1);
                end
            end
        end
    end

    // Sequence state; a last item restarts it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= '0;
            r_window     <= '0;
            r_best       <= '0;
            r_best_start <= SW'(1);
        end else if (w_accept && i_last) begin
            r_seen       <= '0;
            r_window     <= '0;
            r_best       <= '0;
            r_best_start <= SW'(1);
        end else begin
            r_seen       <= n_seen;
            r_window     <= n_window;
            r_best       <= n_best;
            r_best_start <= n_best_start;
        end
    end

    // The two previous samples; before the third sample they are never used.
    always_ff @(posedge i_clk) begin
        if (w_active) begin
            r_older <= r_prior;
            r_prior <= i_sample;
        end
    end

    // Peak history chain.
    assign w_ctl.shift   = w_active;
    assign w_ctl.new_bit = w_peak;
    assign w_ctl.cfg_we  = i_cfg_we;
    assign w_ctl.cfg_kk  = n_kk;

    swpc_chain #(
        .N_CELLS(K_MAX - 2)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_gone  (w_gone)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last) begin
            r_best_pieces    <= swpc_pkg::PIECES_W'(n_best) + swpc_pkg::PIECES_W'(1);
            r_start_position <= swpc_pkg::START_W'(n_best_start);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_best_pieces    = r_best_pieces;
    assign o_start_position = r_start_position;

    // Checks on the block's own bookkeeping.
    `SWPC_ASSERT_NEXT(a_last_gives_result, w_accept && i_last, o_out_valid,
                      "last item did not produce a result")
    `SWPC_ASSERT_NEXT(a_last_clears_count, w_accept && i_last, r_seen == '0,
                      "sample count not cleared after last item")
    `SWPC_ASSERT_ALWAYS(a_seen_bounded, 32'(r_seen) <= 32'(MAX_LEN),
                        "sample count passed its limit")
    `SWPC_ASSERT_ALWAYS(a_result_nonzero,
                        !o_out_valid || (o_best_pieces != '0 && o_start_position != '0),
                        "result holds a zero field")

endmodule

// File: verif/sliding_window_peak_count_test.sv
module sliding_window_peak_count_test;

    localparam int K_MAX        = 1024;
    localparam int MAX_LEN      = 65536;
    localparam int CYCLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT   = 20;
    localparam int BIG_LEN      = 1027;
    localparam int CALM_RUN     = 400;
    localparam int RANDOM_ITEMS = 150;

    // One result of a closed sequence.
    typedef struct {
        logic [swpc_pkg::PIECES_W-1:0] pieces;
        logic [swpc_pkg::START_W-1:0]  start;
    } t_peak_result;

    // Tracks the peak history of the open sequence and holds the results still owed.
    class t_peak_scoreboard;
        logic [swpc_pkg::WLEN_W-1:0]          wlen;
        logic signed [swpc_pkg::SAMPLE_W-1:0] prev1;
        logic signed [swpc_pkg::SAMPLE_W-1:0] prev2;
        int unsigned                          seen;
        bit                                   peak_bits[K_MAX];
        int unsigned                          win_peaks;
        int unsigned                          top_peaks;
        int unsigned                          top_start;
        t_peak_result                         owed_results[$];
        int                                   mismatches;
        int                                   results_checked;

        function new();
            wlen            = swpc_pkg::WLEN_RESET;
            mismatches      = 0;
            results_checked = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            prev1     = '0;
            prev2     = '0;
            seen      = 0;
            win_peaks = 0;
            top_peaks = 0;
            top_start = 1;
            foreach (peak_bits[i]) peak_bits[i] = 1'b0;
        endfunction

        function void set_window_length(logic [swpc_pkg::WLEN_W-1:0] value);
            wlen = value;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Update the running window score with one accepted item.
        function void note_sample(logic signed [swpc_pkg::SAMPLE_W-1:0] s, bit last);
            int unsigned  pos;
            int unsigned  span;
            int unsigned  gone;
            int unsigned  w;
            bit           is_peak;
            t_peak_result res;
            if (seen < MAX_LEN) begin
                pos     = seen + 1;
                span    = (wlen > K_MAX) ? K_MAX : wlen;
                is_peak = (pos >= 3) && (prev1 > prev2) && (prev1 > s);
                if (pos >= 2) peak_bits[(pos - 1) % K_MAX] = is_peak;
                if (span >= 3) begin
                    w = win_peaks + is_peak;
                    if (pos >= span) begin
                        gone = peak_bits[(pos - span + 1) % K_MAX];
                        w = (w >= gone) ? w - gone : 0;
                    end
                    if (w > 1023) w = 1023;
                    win_peaks = w;
                    if (pos >= span && win_peaks > top_peaks) begin
                        top_peaks = win_peaks;
                        top_start = pos - span + 1;
                    end
                end
                prev2 = prev1;
                prev1 = s;
                seen  = pos;
            end
            if (last) begin
                res.pieces   = swpc_pkg::PIECES_W'(top_peaks + 1);
                res.start    = swpc_pkg::START_W'(top_start);
                owed_results = {owed_results, res};
                clear_sequence();
            end
        endfunction

        // Compare one accepted result with the oldest one owed.
        function void check_result(logic [swpc_pkg::PIECES_W-1:0] pieces,
                                   logic [swpc_pkg::START_W-1:0] start);
            t_peak_result want;
            results_checked++;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pieces %0d start %0d", pieces, start);
            end else begin
                want = owed_results.pop_front();
                if (pieces !== want.pieces || start !== want.start) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: pieces %0d (want %0d) start %0d (want %0d)",
                                 pieces, want.pieces, start, want.start);
                end
            end
        endfunction
    endclass

    logic                                 i_clk            = 1'b0;
    logic                                 i_rst_n          = 1'b0;
    logic                                 i_cfg_we         = 1'b0;
    logic [swpc_pkg::WLEN_W-1:0]          i_cfg_wdata      = '0;
    logic                                 i_in_valid       = 1'b0;
    logic                                 o_in_ready;
    logic signed [swpc_pkg::SAMPLE_W-1:0] i_sample         = '0;
    logic                                 i_last           = 1'b0;
    logic                                 o_out_valid;
    logic                                 i_out_ready      = 1'b0;
    logic [swpc_pkg::PIECES_W-1:0]        o_best_pieces;
    logic [swpc_pkg::START_W-1:0]         o_start_position;

    t_peak_scoreboard board = new();
    bit               calm  = 1'b0;
    int               cycle_count = 0;
    int               random_items = 0;

    sliding_window_peak_count #(
        .K_MAX   (K_MAX),
        .MAX_LEN (MAX_LEN)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_best_pieces    (o_best_pieces),
        .o_start_position (o_start_position)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run-away guard.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Result side: check accepted results, then pick the next ready at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_best_pieces, o_start_position);
        i_out_ready <= calm || ($urandom_range(0, 99) >= 12);
    end

    // Offer one item and hold it until the block takes it.
    task automatic send_item(logic signed [swpc_pkg::SAMPLE_W-1:0] s, bit last);
        while (!calm && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_last     <= last;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(s, last);
    endtask

    // Let every owed result drain, then give the block time to settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_window(logic [swpc_pkg::WLEN_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_window_length(value);
    endtask

    // Mostly small values so that peaks and ties are common, sometimes wide ones.
    function automatic logic signed [swpc_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            default: return $signed($urandom_range(0, 8)) - 4;
        endcase
    endfunction

    task automatic send_sequence(int len, bit count_it);
        for (int i = 1; i <= len; i++) begin
            send_item(pick_sample(), i == len);
            if (count_it) random_items++;
        end
    endtask

    initial begin
        int kk;
        int len;
        int phase_no;
        int pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset window of three samples.
        // A lone sample is shorter than any window.
        send_item(32'sd7, 1'b1);
        // Alternating extremes: peaks at every other position.
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7fff_ffff, 1'b1);
        // A flat sequence has no peak.
        send_item(32'sd0, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sd0, 1'b1);
        // Negative neighbors, then a plateau that is not a peak.
        send_item(-32'sd1, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(32'sd4, 1'b1);
        // A peak late in the sequence, with the last sample as the lower neighbor.
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b1);

        // Windows too short to hold an inner sample never score.
        set_window(11'd0);
        send_sequence(6, 1'b0);
        set_window(11'd1);
        send_sequence(5, 1'b0);
        set_window(11'd2);
        send_sequence(7, 1'b0);

        // A length above the largest window acts as it; the first stretch runs
        // without any idling.
        set_window(11'd2047);
        for (int i = 1; i <= BIG_LEN; i++) begin
            calm = (i <= CALM_RUN);
            send_item(pick_sample(), i == BIG_LEN);
        end
        calm = 1'b0;
        // The largest window with a sequence shorter than it.
        set_window(11'd1024);
        send_sequence(9, 1'b0);

        // Random phases, mostly small windows with sequences a few windows long.
        phase_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) kk = $urandom_range(3, 12);
            else if (pick == 6) kk = $urandom_range(13, 40);
            else if (pick == 7) kk = $urandom_range(0, 2);
            else if (pick == 8) kk = 3;
            else kk = $urandom_range(41, 64);
            set_window(swpc_pkg::WLEN_W'(kk));
            calm = (phase_no % 6 == 3);
            if (kk < 3) kk = 3;
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 7) == 0) len = $urandom_range(1, kk - 1);
                else len = $urandom_range(kk, 4 * kk + 4);
                send_sequence(len, 1'b1);
            end
            phase_no++;
        end
        calm = 1'b0;

        // Drain and report.
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/swpc_pkg.sv
rtl/swpc_cell.sv
rtl/swpc_chain.sv
rtl/sliding_window_peak_count.sv
verif/sliding_window_peak_count_test.sv
